// ----- rtl/bbwd_pkg.sv -----
// ----------------------------------------------------------------------------
// bbwd_pkg
// Shared types and constants of the bar-width decoder.
// ----------------------------------------------------------------------------
package bbwd_pkg;

    localparam int unsigned BARS_PER_CHAR = 9;
    localparam int unsigned WIDTH_W       = 16;
    localparam int unsigned SAMPLE_W      = 14;
    localparam int unsigned ASCII_W       = 7;
    localparam int unsigned FILL_W        = 4;

    // Longest run that the counter records; it saturates here.
    localparam logic [WIDTH_W-1:0] RUN_MAX = 16'd65000;

    // Reset level of the color threshold.
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 14'd850;

    // Character reported when nothing matches: ASCII zero.
    localparam logic [ASCII_W-1:0] NO_CHAR = 7'd48;

    // Run colors of a valid window, entry 0 in bit 0: black, white, ..., black.
    localparam logic [BARS_PER_CHAR-1:0] BAR_PATTERN = 9'b101010101;

    // Fill level once the window has been completely written.
    localparam logic [FILL_W-1:0] FILL_FULL = 4'd9;

    // Lowest fill level at which the window may be decoded.
    localparam logic [FILL_W-1:0] FILL_DECODE = 4'd8;

    // Run colors.
    localparam logic COLOR_WHITE = 1'b0;
    localparam logic COLOR_BLACK = 1'b1;

    // Register byte address.
    localparam int unsigned     ADDR_W          = 2;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 2'd0;

    // Nine run widths, entry 0 first.
    typedef logic [BARS_PER_CHAR-1:0][WIDTH_W-1:0] width_arr_t;

    // One decoded direction.
    typedef struct packed {
        logic               found;
        logic [ASCII_W-1:0] ascii;
    } dec_result_t;

endpackage

// ----- rtl/bbwd_decode.sv -----
// ----------------------------------------------------------------------------
// bbwd_decode
// Decodes nine run widths into one character from the positions of the two
// widest black bars and the widest white gap.
// ----------------------------------------------------------------------------
module bbwd_decode
(
    input  bbwd_pkg::width_arr_t  widths,
    output bbwd_pkg::dec_result_t result
);

    // Gap positions that select a character group.
    localparam logic [3:0] GAP_SYMBOLS = 4'd1;
    localparam logic [3:0] GAP_LETTERS_A = 4'd5;
    localparam logic [3:0] GAP_LETTERS_K = 4'd7;

    // Maps a pair of wide bar positions to its place in the character order.
    function automatic logic [4:0] pair_index(input logic [3:0] lo, input logic [3:0] hi);
        logic [4:0] code;
        begin
            // Bit 4 marks a legal pair, bits 3:0 give its place.
            unique case ({lo, hi})
                {4'd0, 4'd8}: code = {1'b1, 4'd0};
                {4'd2, 4'd8}: code = {1'b1, 4'd1};
                {4'd0, 4'd2}: code = {1'b1, 4'd2};
                {4'd4, 4'd8}: code = {1'b1, 4'd3};
                {4'd0, 4'd4}: code = {1'b1, 4'd4};
                {4'd2, 4'd4}: code = {1'b1, 4'd5};
                {4'd6, 4'd8}: code = {1'b1, 4'd6};
                {4'd0, 4'd6}: code = {1'b1, 4'd7};
                {4'd2, 4'd6}: code = {1'b1, 4'd8};
                {4'd4, 4'd6}: code = {1'b1, 4'd9};
                default:      code = 5'd0;
            endcase
            return code;
        end
    endfunction

    logic [bbwd_pkg::WIDTH_W-1:0] big_v;
    logic [bbwd_pkg::WIDTH_W-1:0] sec_v;
    logic [bbwd_pkg::WIDTH_W-1:0] gap_v;
    logic [3:0]                   big_i;
    logic [3:0]                   sec_i;
    logic [3:0]                   gap_i;
    logic [3:0]                   lo;
    logic [3:0]                   hi;
    logic [4:0]                   pair;
    logic                         bar_tie;
    logic                         gap_tie;
    logic [bbwd_pkg::ASCII_W-1:0] ascii;

    always_comb
    begin
        big_v   = '0;
        sec_v   = '0;
        big_i   = 4'd0;
        sec_i   = 4'd0;
        bar_tie = 1'b0;
        gap_tie = 1'b0;

        // Two widest black bars; a strictly wider bar displaces the best.
        for (int b = 0; b < 5; b++)
        begin
            if (widths[2*b] > big_v)
            begin
                sec_v = big_v;
                sec_i = big_i;
                big_v = widths[2*b];
                big_i = 4'(2*b);
            end
            else if (widths[2*b] > sec_v)
            begin
                sec_v = widths[2*b];
                sec_i = 4'(2*b);
            end
        end
        for (int b = 0; b < 5; b++)
        begin
            if (4'(2*b) != big_i && 4'(2*b) != sec_i && widths[2*b] == sec_v)
                bar_tie = 1'b1;
        end

        // Widest white gap, first one kept on equal widths.
        gap_i = 4'd1;
        gap_v = widths[1];
        for (int g = 1; g < 4; g++)
        begin
            if (widths[2*g+1] > gap_v)
            begin
                gap_v = widths[2*g+1];
                gap_i = 4'(2*g+1);
            end
        end
        for (int g = 0; g < 4; g++)
        begin
            if (4'(2*g+1) != gap_i && widths[2*g+1] == gap_v)
                gap_tie = 1'b1;
        end

        lo   = (big_i < sec_i) ? big_i : sec_i;
        hi   = (big_i < sec_i) ? sec_i : big_i;
        pair = pair_index(lo, hi);

        ascii = '0;
        if (!bar_tie && !gap_tie && pair[4])
        begin
            priority if (gap_i == GAP_SYMBOLS)
            begin
                // U..Z for the first six pairs, the star for the last one.
                if (pair[3:0] <= 4'd5)
                    ascii = 7'd85 + {3'd0, pair[3:0]};
                else if (pair[3:0] == 4'd9)
                    ascii = 7'd42;
            end
            else if (gap_i == GAP_LETTERS_A)
                ascii = 7'd65 + {3'd0, pair[3:0]};
            else if (gap_i == GAP_LETTERS_K)
                ascii = 7'd75 + {3'd0, pair[3:0]};
        end

        result.found = (ascii != '0);
        result.ascii = (ascii != '0) ? ascii : bbwd_pkg::NO_CHAR;
    end

endmodule

// ----- rtl/barcode_bar_width_decoder.sv -----
// ----------------------------------------------------------------------------
// barcode_bar_width_decoder
// Classifies reflectance samples as black or white, measures run widths and
// decodes each nine-run window forward and reversed into a character.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_*       in         sample (14 bits), one request per sampling period
//  m_*       out        fwd_found, fwd_char, rev_found, rev_char
//  APB       in/out     color_threshold at byte address 0
//
// One sample is taken every cycle unless a stall holds the input. A sample
// that ends a run passes an input register, a window update and a result
// register before its result shows on m_tvalid. Samples that do not
// end a run, or that leave a window without the black/white pattern, give
// no result. Reset is asynchronous and active low; it restores the threshold
// to 850, an unknown run color, an empty window with all entries black and
// zero wide. A stall on the result side holds the decoded window; only a
// sample that would push into that window waits, others keep flowing.
//
module barcode_bar_width_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    // Sample stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [13:0] sample, [15:14] zero

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] fwd_found, [7:1] fwd_char,
                                    // [8] rev_found, [15:9] rev_char

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NBARS = bbwd_pkg::BARS_PER_CHAR;

    // Configuration.
    logic [bbwd_pkg::SAMPLE_W-1:0] thresh_reg;
    logic                          cfg_write;

    // Input register: the sample is reduced to its color on entry.
    logic                          in_valid_reg;
    logic                          in_col_reg;

    // Run tracking.
    logic                          known_reg;
    logic                          bar_reg;
    logic [bbwd_pkg::WIDTH_W-1:0]  run_reg;
    logic [bbwd_pkg::WIDTH_W-1:0]  run_inc;
    logic                          changed;

    // Window of the last nine runs.
    bbwd_pkg::width_arr_t          width_reg;
    bbwd_pkg::width_arr_t          width_next;
    bbwd_pkg::width_arr_t          width_rev;
    logic [NBARS-1:0]              colors_reg;
    logic [NBARS-1:0]              colors_next;
    logic [bbwd_pkg::FILL_W-1:0]   fill_reg;
    logic [bbwd_pkg::FILL_W-1:0]   fill_next;

    // Decode stage and result register.
    logic                          dec_valid_reg;
    logic                          win_ok;
    bbwd_pkg::dec_result_t         fwd_res;
    bbwd_pkg::dec_result_t         rev_res;
    logic                          out_valid_reg;
    logic [15:0]                   out_data_reg;

    // Flow control.
    logic                          out_free;
    logic                          dec_go;
    logic                          dec_free;
    logic                          upd_go;

    // ------------------------------------------------------------------
    // Configuration port. Writes land in the access phase; reads of any
    // address other than the threshold return zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == bbwd_pkg::REG_THRESHOLD);
    assign prdata    = (paddr == bbwd_pkg::REG_THRESHOLD)
                       ? {18'd0, thresh_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Flow control. The window may change only when the decode stage has
    // finished with it: either the result moved on or there was none.
    // ------------------------------------------------------------------
    assign run_inc  = (run_reg < bbwd_pkg::RUN_MAX) ? run_reg + 16'd1 : run_reg;
    assign changed  = known_reg && (bar_reg != in_col_reg);
    assign win_ok   = (fill_reg >= bbwd_pkg::FILL_DECODE)
                      && (colors_reg == bbwd_pkg::BAR_PATTERN);
    assign out_free = !out_valid_reg || m_tready;
    assign dec_go   = dec_valid_reg && (out_free || !win_ok);
    assign dec_free = !dec_valid_reg || dec_go;
    assign upd_go   = in_valid_reg && (!changed || dec_free);
    assign s_tready = !in_valid_reg || upd_go;

    // ------------------------------------------------------------------
    // Window update. Until the window is full a finished run goes to the
    // next free entry; after that the window shifts down by one and the
    // run enters at the top. The recorded width includes the sample that
    // ended the run.
    // ------------------------------------------------------------------
    always_comb
    begin
        width_next  = width_reg;
        colors_next = colors_reg;
        fill_next   = fill_reg;
        if (upd_go && changed)
        begin
            if (fill_reg == bbwd_pkg::FILL_FULL)
            begin
                for (int j = 0; j < NBARS - 1; j++)
                begin
                    width_next[j]  = width_reg[j+1];
                    colors_next[j] = colors_reg[j+1];
                end
                width_next[NBARS-1]  = run_inc;
                colors_next[NBARS-1] = bar_reg;
            end
            else
            begin
                for (int j = 0; j < NBARS; j++)
                begin
                    if (bbwd_pkg::FILL_W'(j) == fill_reg)
                    begin
                        width_next[j]  = run_inc;
                        colors_next[j] = bar_reg;
                    end
                end
                fill_next = fill_reg + 4'd1;
            end
        end
    end

    // Reversed reading order of the window.
    always_comb
    begin
        for (int j = 0; j < NBARS; j++)
            width_rev[j] = width_reg[NBARS-1-j];
    end

    bbwd_decode u_dec_fwd
    (
        .widths (width_reg),
        .result (fwd_res)
    );

    bbwd_decode u_dec_rev
    (
        .widths (width_rev),
        .result (rev_res)
    );

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= bbwd_pkg::THRESH_RESET;
            in_valid_reg  <= 1'b0;
            known_reg     <= 1'b0;
            bar_reg       <= bbwd_pkg::COLOR_BLACK;
            run_reg       <= '0;
            width_reg     <= '0;
            colors_reg    <= '1;
            fill_reg      <= '0;
            dec_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                thresh_reg <= pwdata[bbwd_pkg::SAMPLE_W-1:0];

            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (upd_go)
                in_valid_reg <= 1'b0;

            if (upd_go)
            begin
                known_reg <= 1'b1;
                bar_reg   <= in_col_reg;
                run_reg   <= changed ? '0 : run_inc;
            end

            width_reg  <= width_next;
            colors_reg <= colors_next;
            fill_reg   <= fill_next;

            if (upd_go && changed)
                dec_valid_reg <= 1'b1;
            else if (dec_go)
                dec_valid_reg <= 1'b0;

            if (dec_go && win_ok)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_col_reg <= (s_tdata[bbwd_pkg::SAMPLE_W-1:0] < thresh_reg)
                          ? bbwd_pkg::COLOR_WHITE : bbwd_pkg::COLOR_BLACK;
        if (dec_go && win_ok)
            out_data_reg <= {rev_res.ascii, rev_res.found, fwd_res.ascii, fwd_res.found};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bbwd_pkg::FILL_FULL)
        else $error("window fill level out of range");

    a_run_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= bbwd_pkg::RUN_MAX)
        else $error("run counter passed its saturation value");

    a_window_held: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid_reg && !dec_go) |=> $stable(width_reg) && $stable(colors_reg))
        else $error("window changed while its decode was pending");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(dec_valid_reg))
        else $error("result appeared without a decoded window");

    a_color_known: assert property (@(posedge clk) disable iff (!rst_n)
        known_reg |=> known_reg)
        else $error("run color returned to unknown");

endmodule

// ----- sim/barcode_bar_width_decoder_test.sv -----
// ----------------------------------------------------------------------------
// barcode_bar_width_decoder_test
// Self-checking bench for the bar-width decoder. Sample streams are built
// from Code 39 style bar patterns, broken patterns and noise. Each accepted
// sample runs through a local copy of the run tracker and the character
// decoder, and every result request is checked against the oldest expected
// character pair. The threshold register is moved through several levels,
// the extremes among them.
// ----------------------------------------------------------------------------
module barcode_bar_width_decoder_test;

    import bbwd_pkg::*;

    // Cycles without any accepted request before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off plus a long
    // sender gap, well below this.
    localparam int WATCHDOG_LIMIT = 3000;

    // The receiver holds off once, for this long, after this many results.
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 400;

    // The window holds one more entry than a character needs.
    localparam int WIN_DEPTH = BARS_PER_CHAR + 1;

    // One expected result request: forward and reversed decode.
    typedef struct {
        dec_result_t fwd;
        dec_result_t rev;
    } char_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    barcode_bar_width_decoder DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------

    logic [SAMPLE_W-1:0] sample_backlog[$];   // samples not yet offered
    char_pair_t          char_expect[$];      // decodes not yet seen
    int                  queued_samples = 0;
    int                  n_offered = 0;
    int                  n_taken = 0;
    int                  results_seen = 0;
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    bit                  quiet_mode = 1'b0;   // no gaps and no stalls

    // Local copy of the block's threshold and run tracker.
    logic [SAMPLE_W-1:0] thr_model = THRESH_RESET;
    logic                cur_color = COLOR_BLACK;
    logic                color_known = 1'b0;
    logic [WIDTH_W-1:0]  run_len = '0;
    logic [WIDTH_W-1:0]  width_log[WIN_DEPTH];
    logic                color_log[WIN_DEPTH];
    int                  fill_level = 0;

    initial
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            width_log[i] = '0;
            color_log[i] = COLOR_BLACK;
        end
    end

    // ------------------------------------------------------------------------
    // Character decoder
    // ------------------------------------------------------------------------

    // Finds the two widest black bars and the widest white gap of nine runs
    // and looks the combination up in the character table. A tie with the
    // second widest bar or with the widest gap gives no character.
    function automatic dec_result_t decode_char(input width_arr_t w);
        int                 top_i;
        int                 next_i;
        int                 gap_i;
        int                 lo;
        int                 hi;
        int                 pair_k;
        logic [WIDTH_W-1:0] top_v;
        logic [WIDTH_W-1:0] next_v;
        logic               clash;
        logic [7:0]         code;
        dec_result_t        r;
        top_i  = 0;
        next_i = 0;
        top_v  = '0;
        next_v = '0;
        gap_i  = 1;
        clash  = 1'b0;
        code   = 8'd0;
        for (int i = 0; i < BARS_PER_CHAR; i += 2)
        begin
            if (w[i] > top_v)
            begin
                next_v = top_v;
                next_i = top_i;
                top_v  = w[i];
                top_i  = i;
            end
            else if (w[i] > next_v)
            begin
                next_v = w[i];
                next_i = i;
            end
        end
        for (int i = 0; i < BARS_PER_CHAR; i += 2)
        begin
            if (i != top_i && i != next_i && w[i] == next_v)
                clash = 1'b1;
        end
        for (int i = 3; i < BARS_PER_CHAR; i += 2)
        begin
            if (w[i] > w[gap_i])
                gap_i = i;
        end
        for (int i = 1; i < BARS_PER_CHAR; i += 2)
        begin
            if (i != gap_i && w[i] == w[gap_i])
                clash = 1'b1;
        end
        lo = (top_i < next_i) ? top_i : next_i;
        hi = (top_i < next_i) ? next_i : top_i;
        // Position of the wide bar pair in the table.
        case ({lo[3:0], hi[3:0]})
            8'h08:   pair_k = 0;
            8'h28:   pair_k = 1;
            8'h02:   pair_k = 2;
            8'h48:   pair_k = 3;
            8'h04:   pair_k = 4;
            8'h24:   pair_k = 5;
            8'h68:   pair_k = 6;
            8'h06:   pair_k = 7;
            8'h26:   pair_k = 8;
            8'h46:   pair_k = 9;
            default: pair_k = -1;
        endcase
        if (!clash && pair_k >= 0)
        begin
            case (gap_i)
                1:
                begin
                    // U..Z for the first six pairs, the star for the last.
                    if (pair_k < 6)
                        code = 8'("U" + pair_k);
                    else if (pair_k == 9)
                        code = "*";
                end
                5:       code = 8'("A" + pair_k);
                7:       code = 8'("K" + pair_k);
                default: code = 8'd0;
            endcase
        end
        r.found = (code != 8'd0);
        r.ascii = r.found ? code[ASCII_W-1:0] : NO_CHAR;
        return r;
    endfunction

    // Advances the run tracker by one accepted sample. A color change pushes
    // the finished run (including the sample that ended it) into the window;
    // a push that leaves black/white/.../black in entries 0..8 yields one
    // expected result.
    task automatic track_sample(input logic [SAMPLE_W-1:0] smp);
        logic       col;
        logic       pushed;
        logic       pattern_ok;
        int         pos;
        width_arr_t fw;
        width_arr_t rw;
        char_pair_t due;
        col    = (smp < thr_model) ? COLOR_WHITE : COLOR_BLACK;
        pushed = 1'b0;
        if (!color_known)
        begin
            cur_color   = col;
            color_known = 1'b1;
        end
        if (run_len < RUN_MAX)
            run_len++;
        if (cur_color != col)
        begin
            pos = (fill_level < WIN_DEPTH) ? fill_level : WIN_DEPTH - 1;
            color_log[pos] = cur_color;
            width_log[pos] = run_len;
            fill_level = pos + 1;
            if (fill_level >= WIN_DEPTH)
            begin
                // Slide by one; the last entry keeps its old contents.
                for (int i = 0; i + 1 < WIN_DEPTH; i++)
                begin
                    width_log[i] = width_log[i + 1];
                    color_log[i] = color_log[i + 1];
                end
                fill_level = WIN_DEPTH - 1;
            end
            run_len = '0;
            pushed  = 1'b1;
        end
        cur_color = col;

        pattern_ok = (fill_level >= FILL_DECODE);
        for (int i = 0; i < BARS_PER_CHAR; i++)
        begin
            if (color_log[i] != BAR_PATTERN[i])
                pattern_ok = 1'b0;
        end
        if (pushed && pattern_ok)
        begin
            for (int i = 0; i < BARS_PER_CHAR; i++)
            begin
                fw[i] = width_log[i];
                rw[i] = width_log[BARS_PER_CHAR - 1 - i];
            end
            due.fwd = decode_char(fw);
            due.rev = decode_char(rw);
            char_expect.push_back(due);
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d (result %0d)",
                 field, got, want, results_seen);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sample driver: offers the backlog one request at a time, holding each
    // until it is taken, with random gaps between requests.
    // ------------------------------------------------------------------------

    int send_gap = 0;

    function automatic int pick_gap();
        int roll;
        if (quiet_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && n_taken != n_offered))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_backlog.size() > 0)
            begin
                s_tdata  <= {2'b00, sample_backlog.pop_front()};
                s_tvalid <= 1'b1;
                n_offered++;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: short random stalls, a few long ones, and one long
    // hold-off that lets the block back up into its sample input.
    // ------------------------------------------------------------------------

    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  roll_rx;
    logic ready_next;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            ready_next = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                ready_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (!quiet_mode)
            begin
                roll_rx = $urandom_range(0, 99);
                if (roll_rx < 20)
                begin
                    stall_left = $urandom_range(0, 2);
                    ready_next = 1'b0;
                end
                else if (roll_rx < 22)
                begin
                    stall_left = $urandom_range(15, 60);
                    ready_next = 1'b0;
                end
            end
            m_tready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog, both at the rising edge.
    // ------------------------------------------------------------------------

    char_pair_t due_now;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (char_expect.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 0);
                else
                begin
                    due_now = char_expect.pop_front();
                    if (m_tdata[0] != due_now.fwd.found)
                        report_mismatch("fwd_found", m_tdata[0], due_now.fwd.found);
                    if (m_tdata[7:1] != due_now.fwd.ascii)
                        report_mismatch("fwd_char", m_tdata[7:1], due_now.fwd.ascii);
                    if (m_tdata[8] != due_now.rev.found)
                        report_mismatch("rev_found", m_tdata[8], due_now.rev.found);
                    if (m_tdata[15:9] != due_now.rev.ascii)
                        report_mismatch("rev_char", m_tdata[15:9], due_now.rev.ascii);
                end
            end
            if (s_tvalid && s_tready)
            begin
                n_taken++;
                track_sample(s_tdata[SAMPLE_W-1:0]);
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request accepted for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_sample(input logic [SAMPLE_W-1:0] smp);
        sample_backlog.push_back(smp);
        queued_samples++;
    endtask

    // A run of len samples of one color. Levels right at the threshold turn
    // up now and then. With a zero threshold no sample can be white, so the
    // run comes out black.
    task automatic emit_run(input logic black, input int len);
        logic [SAMPLE_W-1:0] lvl;
        for (int i = 0; i < len; i++)
        begin
            if (black || thr_model == 0)
                lvl = ($urandom_range(0, 7) == 0)
                      ? thr_model
                      : SAMPLE_W'($urandom_range(thr_model, 16383));
            else
                lvl = ($urandom_range(0, 7) == 0)
                      ? SAMPLE_W'(thr_model - 1)
                      : SAMPLE_W'($urandom_range(0, thr_model - 1));
            queue_sample(lvl);
        end
    endtask

    // Nine alternating runs shaped like a character: two wide bars, one wide
    // gap. Some get a stray width (ties, unknown pairs) or a very wide run.
    // A white quiet zone of random length follows.
    task automatic emit_char();
        int widths[BARS_PER_CHAR];
        int narrow;
        int gap_pos;
        int bar_a;
        int bar_b;
        int roll;
        narrow = $urandom_range(1, 3);
        for (int i = 0; i < BARS_PER_CHAR; i++)
            widths[i] = narrow;
        gap_pos = 2 * $urandom_range(0, 3) + 1;
        bar_a   = $urandom_range(0, 4);
        bar_b   = (bar_a + $urandom_range(1, 4)) % 5;
        widths[gap_pos]   = narrow + $urandom_range(1, 5);
        widths[2 * bar_a] = narrow + $urandom_range(1, 5);
        widths[2 * bar_b] = narrow + $urandom_range(1, 5);
        roll = $urandom_range(0, 99);
        if (roll < 15)
            widths[$urandom_range(0, BARS_PER_CHAR - 1)] = $urandom_range(1, 8);
        else if (roll < 18)
            widths[$urandom_range(0, BARS_PER_CHAR - 1)] = $urandom_range(40, 200);
        for (int i = 0; i < BARS_PER_CHAR; i++)
            emit_run((i % 2) == 0, widths[i]);
        emit_run(1'b0, $urandom_range(1, 10));
    endtask

    // Mostly characters, one burst in ten is raw noise over the full range.
    task automatic queue_stream(input int count);
        int start;
        start = queued_samples;
        while (queued_samples - start < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                for (int i = $urandom_range(1, 16); i > 0; i--)
                    queue_sample(SAMPLE_W'($urandom_range(0, 16383)));
            end
            else
                emit_char();
        end
    endtask

    // Waits until every sample is taken and every result has arrived, then
    // lets the pipeline drain of samples that produce nothing.
    task automatic wait_idle();
        while (sample_backlog.size() != 0 || n_taken != n_offered ||
               char_expect.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Writes the threshold (setup then access phase) and reads it back.
    task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
        logic [31:0] rd_value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_THRESHOLD;
        pwdata  <= {18'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        thr_model = value;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd_value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd_value[SAMPLE_W-1:0] != value)
            report_mismatch("color_threshold readback", rd_value[SAMPLE_W-1:0], value);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    // Directed samples around a threshold of 1000: both extremes, levels on
    // either side of the threshold, alternating bit patterns. The early runs
    // reach a decode with only eight entries written, so the last entry
    // still holds its reset color and zero width.
    localparam logic [SAMPLE_W-1:0] DIRECTED[23] = '{
        14'd16383, 14'd1000, 14'd999,  14'd16383, 14'd0,    14'd1000,
        14'd999,   14'd0,    14'd8192, 14'h1555,  14'd999,  14'h2AAA,
        14'h2AAA,  14'd0,    14'd999,  14'd0,     14'd16383, 14'd0,
        14'd1000,  14'd1000, 14'd0,    14'd16383, 14'd0
    };

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_threshold(14'd1000);
        foreach (DIRECTED[i])
            queue_sample(DIRECTED[i]);
        wait_idle();

        // Reset level again, with gaps and stalls. One long black run sits
        // in the middle.
        write_threshold(THRESH_RESET);
        quiet_mode = 1'b0;
        queue_stream(350);
        emit_run(1'b1, 150);
        queue_stream(60);
        wait_idle();

        // Zero threshold: nothing is white, so at most one run ends.
        write_threshold(14'd0);
        quiet_mode = 1'b1;
        queue_stream(100);
        wait_idle();

        // Top threshold: only full scale counts as black.
        write_threshold(14'd16383);
        quiet_mode = 1'b0;
        queue_stream(350);
        wait_idle();

        // Only zero counts as white.
        write_threshold(14'd1);
        queue_stream(300);
        wait_idle();

        // Random level, back to back in both directions.
        write_threshold(SAMPLE_W'($urandom_range(2, 16382)));
        quiet_mode = 1'b1;
        queue_stream(300);
        wait_idle();

        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && char_expect.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bbwd_pkg.sv
rtl/bbwd_decode.sv
rtl/barcode_bar_width_decoder.sv
sim/barcode_bar_width_decoder_test.sv
